/* rtl/core/efd_pkg.sv */
// ----------------------------------------------------------------------------
// efd_pkg
// Shared types and constants of the ev1527 frame decoder: field widths,
// status codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package efd_pkg;

  // field widths
  localparam int unsigned WIDTH_W   = 15;
  localparam int unsigned ADDR_W    = 20;
  localparam int unsigned NIBBLE_W  = 4;
  localparam int unsigned BITS_W    = ADDR_W + NIBBLE_W;
  localparam int unsigned TICK_W    = 10;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned SUM_W     = WIDTH_W + 1;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = ADDR_W;

  // frame layout
  localparam logic [COUNT_W-1:0] FRAME_SYMBOLS = 5'd25;
  localparam logic [4:0]         SYNC_UNITS    = 5'd31;
  localparam logic [1:0]         BIT_UNITS     = 2'd2;

  // data nibble commands
  localparam logic [NIBBLE_W-1:0] NIB_AUTO_MANUAL = 4'b0001;
  localparam logic [NIBBLE_W-1:0] NIB_OFF         = 4'b0010;

  // command field values
  localparam logic CMD_AUTO_MANUAL = 1'b0;
  localparam logic CMD_OFF         = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SYNC = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ADDR     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DATA     = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAIRED_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLACK_TICKS    = 2'd2;

  // register reset values
  localparam logic [ADDR_W-1:0] RST_PAIRED_ADDRESS = 20'd0;
  localparam logic [TICK_W-1:0] RST_UNIT_TICKS     = 10'd300;
  localparam logic [TICK_W-1:0] RST_SLACK_TICKS    = 10'd150;

  typedef struct packed {
    logic [ADDR_W-1:0] paired_address;
    logic [TICK_W-1:0] unit_ticks;
    logic [TICK_W-1:0] slack_ticks;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                command;
    logic [ADDR_W-1:0]   address;
    logic [NIBBLE_W-1:0] data_nibble;
  } result_t;

endpackage

/* rtl/core/efd_if.sv */
// ----------------------------------------------------------------------------
// efd_if
// Valid/ready channels of the ev1527 frame decoder: symbol input,
// frame result output and register write port.
// ----------------------------------------------------------------------------
interface efd_sym_if;
  import efd_pkg::*;

  logic               valid;
  logic               ready;
  logic [WIDTH_W-1:0] high_width;
  logic [WIDTH_W-1:0] low_width;
  logic               end_of_frame;

  modport source (output valid, output high_width, output low_width,
                  output end_of_frame, input ready);
  modport sink   (input valid, input high_width, input low_width,
                  input end_of_frame, output ready);
endinterface

interface efd_res_if;
  import efd_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                command;
  logic [ADDR_W-1:0]   address;
  logic [NIBBLE_W-1:0] data_nibble;

  modport source (output valid, output status, output command,
                  output address, output data_nibble, input ready);
  modport sink   (input valid, input status, input command,
                  input address, input data_nibble, output ready);
endinterface

interface efd_cfg_if;
  import efd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/ev1527_frame_decoder_core.sv */
// ----------------------------------------------------------------------------
// ev1527_frame_decoder_core
// Decodes ev1527 remote frames from received pulse symbols.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one pulse symbol per transfer (high width, low width in ticks,
//            end-of-frame mark). The first symbol of a frame is the sync,
//            the next 24 carry address and data bits; later ones are ignored.
//   out_ch : one result per frame, issued for the end-of-frame symbol:
//            status, command, decoded address and data nibble.
//   cfg_ch : register writes (index, data); always ready. Write only while
//            the decoder is idle.
// Each symbol is registered at the input, decoded against the frame state,
// and its result is registered for out_ch.
// Throughput: one symbol per cycle, but an end-of-frame symbol can be held.
// When out_ch stalls, the output register holds its result; symbols without
// end-of-frame keep flowing, and an end-of-frame symbol waits in the input
// register, which then drops in_ch ready.
// Reset clears the frame state and loads the register defaults (address 0,
// unit 300 ticks, slack 150 ticks).
// ----------------------------------------------------------------------------
module ev1527_frame_decoder_core (
  input  logic      clk,
  input  logic      rst_n,
  efd_sym_if.sink   in_ch,
  efd_res_if.source out_ch,
  efd_cfg_if.sink   cfg_ch
);
  import efd_pkg::*;

  cfg_t    cfg;
  result_t frame_res;

  logic               in_vld_r;
  logic [WIDTH_W-1:0] in_high_r;
  logic [WIDTH_W-1:0] in_low_r;
  logic               in_eof_r;

  logic    out_vld_r, out_vld_nxt;
  result_t out_res_r;

  logic out_free, step, in_xfer;

  // register port
  assign cfg_ch.ready = 1'b1;

  efd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // handshake: a result symbol needs a free output register
  assign out_free    = !out_vld_r || out_ch.ready;
  assign step        = in_vld_r && (!in_eof_r || out_free);
  assign in_ch.ready = !in_vld_r || step;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_high_r <= in_ch.high_width;
      in_low_r  <= in_ch.low_width;
      in_eof_r  <= in_ch.end_of_frame;
    end
  end

  efd_frame u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .high_width   (in_high_r),
    .low_width    (in_low_r),
    .end_of_frame (in_eof_r),
    .cfg          (cfg),
    .result       (frame_res)
  );

  // output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (step && in_eof_r) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_eof_r) begin
      out_res_r <= frame_res;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.command     = out_res_r.command;
  assign out_ch.address     = out_res_r.address;
  assign out_ch.data_nibble = out_res_r.data_nibble;

endmodule

/* rtl/core/efd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// efd_cfg_regs
// Register file of the decoder: paired address, unit and slack ticks.
// Writes to an index outside the list are taken and dropped.
// ----------------------------------------------------------------------------
module efd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [efd_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [efd_pkg::CFG_DAT_W-1:0] wr_data,
  output efd_pkg::cfg_t                 cfg
);
  import efd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_PAIRED_ADDRESS: cfg_nxt.paired_address = wr_data;
        CFG_UNIT_TICKS:     cfg_nxt.unit_ticks     = wr_data[TICK_W-1:0];
        CFG_SLACK_TICKS:    cfg_nxt.slack_ticks    = wr_data[TICK_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.paired_address <= RST_PAIRED_ADDRESS;
      cfg_r.unit_ticks     <= RST_UNIT_TICKS;
      cfg_r.slack_ticks    <= RST_SLACK_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/efd_frame.sv */
// ----------------------------------------------------------------------------
// efd_frame
// Frame state of the decoder: symbol count, sync flag and bit shifter.
// Classifies one symbol per step and forms the frame result on the
// end-of-frame symbol, then clears the frame.
// ----------------------------------------------------------------------------
module efd_frame (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [efd_pkg::WIDTH_W-1:0] high_width,
  input  logic [efd_pkg::WIDTH_W-1:0] low_width,
  input  logic                        end_of_frame,
  input  efd_pkg::cfg_t               cfg,
  output efd_pkg::result_t            result
);
  import efd_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               sync_r, sync_nxt;
  logic [BITS_W-1:0]  shift_r, shift_nxt;

  logic [COUNT_W-1:0] count_upd;
  logic               sync_upd;
  logic [BITS_W-1:0]  shift_upd;

  logic [SUM_W-1:0] sync_sum, sync_ref, bit_sum, bit_ref;
  logic             sync_ok, bit_one;
  logic [ADDR_W-1:0]   dec_addr;
  logic [NIBBLE_W-1:0] dec_nib;

  // thresholds moved to the left side: width + slack vs units * unit
  assign sync_sum = {1'b0, low_width} + {{(SUM_W-TICK_W){1'b0}}, cfg.slack_ticks};
  assign sync_ref = {{(SUM_W-TICK_W){1'b0}}, cfg.unit_ticks}
                  * {{(SUM_W-5){1'b0}}, SYNC_UNITS};
  assign bit_sum  = {1'b0, high_width} + {{(SUM_W-TICK_W){1'b0}}, cfg.slack_ticks};
  assign bit_ref  = {{(SUM_W-TICK_W){1'b0}}, cfg.unit_ticks}
                  * {{(SUM_W-2){1'b0}}, BIT_UNITS};
  assign sync_ok  = (sync_sum >= sync_ref);
  assign bit_one  = (bit_sum > bit_ref);

  // per-symbol state update
  always_comb begin
    count_upd = count_r;
    sync_upd  = sync_r;
    shift_upd = shift_r;
    if (count_r == '0) begin
      sync_upd  = sync_ok;
      count_upd = COUNT_W'(1);
    end else if (count_r < FRAME_SYMBOLS) begin
      shift_upd = {shift_r[BITS_W-2:0], bit_one};
      count_upd = count_r + COUNT_W'(1);
    end
  end

  // frame result from the updated state
  assign dec_addr = shift_upd[BITS_W-1:NIBBLE_W];
  assign dec_nib  = shift_upd[NIBBLE_W-1:0];

  always_comb begin
    result.command     = CMD_AUTO_MANUAL;
    result.address     = dec_addr;
    result.data_nibble = dec_nib;
    priority if (count_upd < FRAME_SYMBOLS) begin
      result.status      = ST_SHORT;
      result.address     = '0;
      result.data_nibble = '0;
    end else if (!sync_upd) begin
      result.status = ST_BAD_SYNC;
    end else if (cfg.paired_address != '0 && dec_addr != cfg.paired_address) begin
      result.status = ST_ADDR;
    end else if (dec_nib == NIB_AUTO_MANUAL) begin
      result.status = ST_OK;
    end else if (dec_nib == NIB_OFF) begin
      result.status  = ST_OK;
      result.command = CMD_OFF;
    end else begin
      result.status = ST_DATA;
    end
  end

  // clear after the end-of-frame symbol
  always_comb begin
    count_nxt = count_r;
    sync_nxt  = sync_r;
    shift_nxt = shift_r;
    if (step) begin
      if (end_of_frame) begin
        count_nxt = '0;
        sync_nxt  = 1'b0;
        shift_nxt = '0;
      end else begin
        count_nxt = count_upd;
        sync_nxt  = sync_upd;
        shift_nxt = shift_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sync_r  <= 1'b0;
      shift_r <= '0;
    end else begin
      count_r <= count_nxt;
      sync_r  <= sync_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule
